// ===== design/gha_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gha_pkg
// Types and constants shared by the generational handle allocator.
// ----------------------------------------------------------------------------
package gha_pkg;

  localparam int unsigned SLOTS  = 256;
  localparam int unsigned IDX_W  = 9;               // handle index, 0 is null
  localparam int unsigned GEN_W  = 16;              // generation field
  localparam int unsigned ADDR_W = $clog2(SLOTS);   // slot / stack address
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_CHECK   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_FULL     = 2'd1,
    ERR_NOT_LIVE = 2'd2
  } error_e;

  typedef struct packed {
    action_e            action;
    logic [IDX_W-1:0]   handle_index;
    logic [GEN_W-1:0]   handle_generation;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]   out_index;
    logic [GEN_W-1:0]   out_generation;
    logic               is_live;
    error_e             error;
  } rsp_t;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [GEN_W-1:0]   generation;
  } handle_t;

endpackage : gha_pkg
`default_nettype wire

// ===== design/generational_handle_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Hands out (index, generation) handles from a free stack and a slot table.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_i: action, handle_index, handle_generation) is taken
//   at a rising edge with start high and busy low. Actions: allocate, release
//   a handle, check a handle.
//   In the accept cycle the free stack and the generation table are read
//   (synchronous memories). In the following cycle busy is high; the entry
//   is modified and written back and the result is registered. The result
//   beat shows on rsp_o with done_o high for exactly one cycle, once the
//   busy cycle is over, and is taken at the edge that ends it. busy is low
//   in that cycle, so the next request may be taken while the result is on
//   the ports.
//   A new request is taken only once the last one has left the busy state,
//   as each request needs the read and the write-back of the memories.
//   The receiver cannot stall; each result must be taken in its cycle.
//   Reset clears the live marks, the free count, the fresh index counter and
//   the control state at once; the stack and generation memories need no
//   clearing since only written entries are ever used. No clearing pass.
// ----------------------------------------------------------------------------
module generational_handle_allocator
  import gha_pkg::*;
(
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic start,
  output logic       busy,
  input  wire  req_t req_i,
  output logic       done_o,
  output rsp_t       rsp_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // memories
  handle_t          stack_mem [SLOTS];
  logic [GEN_W-1:0] gen_mem   [SLOTS];
  handle_t          stack_rd_q;
  logic [GEN_W-1:0] gen_rd_q;

  logic [SLOTS-1:0] live_q, live_d;
  logic [CNT_W-1:0] free_count_q, free_count_d;
  logic [CNT_W-1:0] next_fresh_q, next_fresh_d;
  logic             state_q, state_d;
  logic             done_q;
  rsp_t             rsp_q, rsp_d;

  // captured request
  action_e          act_q;
  logic [IDX_W-1:0] idx_q;
  logic [GEN_W-1:0] gen_q;
  logic             in_range_q;
  logic             live_rd_q;

  logic             accept;
  logic             in_range;
  logic [ADDR_W-1:0] req_addr;
  logic [ADDR_W-1:0] pop_addr;

  logic             stack_we;
  logic [ADDR_W-1:0] stack_waddr;
  handle_t          stack_wdata;
  logic             gen_we;
  logic [ADDR_W-1:0] gen_waddr;
  logic [GEN_W-1:0] gen_wdata;
  logic             match;

  assign busy   = (state_q == ST_EXEC);
  assign accept = start && !busy;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  assign in_range = (req_i.handle_index != '0) &&
                    (req_i.handle_index <= IDX_W'(SLOTS));
  assign req_addr = ADDR_W'(req_i.handle_index - IDX_W'(1));
  assign pop_addr = ADDR_W'(free_count_q - CNT_W'(1));

  // read port: one access each, issued at the accept edge
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stack_rd_q <= stack_mem[pop_addr];
      gen_rd_q   <= gen_mem[req_addr];
      live_rd_q  <= live_q[req_addr];
      act_q      <= req_i.action;
      idx_q      <= req_i.handle_index;
      gen_q      <= req_i.handle_generation;
      in_range_q <= in_range;
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wdata;
    end
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
  end

  assign match = in_range_q && live_rd_q && (gen_rd_q == gen_q);

  always_comb begin
    state_d      = state_q;
    live_d       = live_q;
    free_count_d = free_count_q;
    next_fresh_d = next_fresh_q;
    rsp_d        = '0;
    stack_we     = 1'b0;
    stack_waddr  = free_count_q[ADDR_W-1:0];
    stack_wdata  = '{index: idx_q, generation: gen_q};
    gen_we       = 1'b0;
    gen_waddr    = next_fresh_q[ADDR_W-1:0];
    gen_wdata    = '0;

    if (state_q == ST_IDLE) begin
      if (accept) begin
        state_d = ST_EXEC;
      end
    end else begin
      state_d = ST_IDLE;
      unique case (act_q)
        ACT_ALLOC: begin
          if (free_count_q != '0) begin
            // pop the most recently released handle, bump its generation
            free_count_d            = free_count_q - CNT_W'(1);
            gen_we                  = 1'b1;
            gen_waddr               = ADDR_W'(stack_rd_q.index - IDX_W'(1));
            gen_wdata               = stack_rd_q.generation + GEN_W'(1);
            live_d[gen_waddr]       = 1'b1;
            rsp_d.out_index         = stack_rd_q.index;
            rsp_d.out_generation    = gen_wdata;
          end else if (next_fresh_q < CNT_W'(SLOTS)) begin
            next_fresh_d            = next_fresh_q + CNT_W'(1);
            gen_we                  = 1'b1;
            live_d[gen_waddr]       = 1'b1;
            rsp_d.out_index         = IDX_W'(next_fresh_q) + IDX_W'(1);
          end else begin
            rsp_d.error             = ERR_FULL;
          end
        end
        ACT_RELEASE: begin
          if (match && free_count_q < CNT_W'(SLOTS)) begin
            live_d[ADDR_W'(idx_q - IDX_W'(1))] = 1'b0;
            stack_we     = 1'b1;
            free_count_d = free_count_q + CNT_W'(1);
          end else begin
            rsp_d.error  = ERR_NOT_LIVE;
          end
        end
        ACT_CHECK: begin
          rsp_d.is_live = match;
        end
        default: begin
          // unused action code: zero result, no state change
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      live_q       <= '0;
      free_count_q <= '0;
      next_fresh_q <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      live_q       <= live_d;
      free_count_q <= free_count_d;
      next_fresh_q <= next_fresh_d;
      done_q       <= busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) begin
      rsp_q <= rsp_d;
    end
  end

  // checks
  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy) else $error("exec state held more than one cycle");

  a_done_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o) else $error("result beat missing after exec");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !done_o) else $error("result beat without a request");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_count_q <= CNT_W'(SLOTS)) && (next_fresh_q <= CNT_W'(SLOTS)))
    else $error("free count or fresh index out of range");

  a_full_only_when_exhausted: assert property (@(posedge clk_i)
    disable iff (!rst_ni)
    (done_o && rsp_o.error == ERR_FULL) |->
      (free_count_q == '0 && next_fresh_q == CNT_W'(SLOTS)))
    else $error("full flagged while handles remain");

  a_alloc_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.out_index != '0) |->
      (rsp_o.error == ERR_NONE && live_q[ADDR_W'(rsp_o.out_index - IDX_W'(1))]))
    else $error("issued handle not marked live");

endmodule : generational_handle_allocator
`default_nettype wire
